// ===== src/avcc_pkg.sv =====
package avcc_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int PKT_LEN_W       = 24;
	localparam int STAMP_W         = 64;
	localparam int LEN_W           = 32;

	localparam int S_TDATA_W = 96;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 3;

	typedef enum logic [2:0] {
		PH_DISCARD = 3'b001,
		PH_PREFIX  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_BYTE,
		RES_START
	} res_kind_t;

	typedef struct packed {
		logic [7:0]                in_byte;
		logic                      packet_first;
		logic [PKT_LEN_W-1:0]      packet_length;
		logic                      key_frame_in;
		logic signed [STAMP_W-1:0] stamp_in;
	} in_item_t;

	// what one request produces: nothing, one payload byte or a start code burst
	typedef struct packed {
		res_kind_t                 kind;
		logic [7:0]                data;
		logic                      unit_end;
		logic                      key_frame;
		logic signed [STAMP_W-1:0] stamp;
	} res_desc_t;

	function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd3:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== src/avcc_parse.sv =====
module avcc_parse #(
	parameter int LENGTH_BITS = avcc_pkg::LENGTH_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  avcc_pkg::in_item_t  item,
	input  logic                consume,
	output avcc_pkg::res_desc_t res
);
	import avcc_pkg::*;

	phase_t                    phase_q;
	logic [1:0]                prefix_count_q;
	logic [PKT_LEN_W-1:0]      prefix_bytes_q;
	logic [PKT_LEN_W-1:0]      packet_left_q;
	logic [PKT_LEN_W-1:0]      unit_left_q;
	logic                      key_held_q;
	logic signed [STAMP_W-1:0] stamp_held_q;

	phase_t                    ph, ph_n;
	logic [1:0]                pc, pc_n;
	logic [PKT_LEN_W-1:0]      pb, pb_n;
	logic [PKT_LEN_W-1:0]      pl, pl_n, pl_dec;
	logic [PKT_LEN_W-1:0]      ul, ul_n, ul_dec;
	logic                      key;
	logic signed [STAMP_W-1:0] stamp;
	logic [LEN_W-1:0]          len;
	logic                      len_bad;

	always_comb begin
		ph    = phase_q;
		pc    = prefix_count_q;
		pb    = prefix_bytes_q;
		pl    = packet_left_q;
		ul    = unit_left_q;
		key   = key_held_q;
		stamp = stamp_held_q;
		// packet start reloads everything before the byte itself is looked at
		if (item.packet_first) begin
			pl    = item.packet_length;
			key   = item.key_frame_in;
			stamp = item.stamp_in;
			pc    = 2'd0;
			pb    = '0;
			ul    = '0;
			ph    = (item.packet_length != '0) ? PH_PREFIX : PH_DISCARD;
		end

		pl_dec  = pl - PKT_LEN_W'(1);
		ul_dec  = ul - PKT_LEN_W'(1);
		len     = {pb, item.in_byte};
		len_bad = (len == '0) || ((len >> LENGTH_BITS) != '0) ||
			(len > {{(LEN_W-PKT_LEN_W){1'b0}}, pl_dec});

		ph_n = ph;
		pc_n = pc;
		pb_n = pb;
		pl_n = pl;
		ul_n = ul;

		res.kind      = RES_NONE;
		res.data      = item.in_byte;
		res.unit_end  = 1'b0;
		res.key_frame = key;
		res.stamp     = stamp;

		unique case (ph)
			PH_PREFIX: begin
				pl_n = pl_dec;
				if (pc != 2'd3) begin
					pb_n = {pb[PKT_LEN_W-9:0], item.in_byte};
					pc_n = pc + 2'd1;
					if (pl_dec == '0)
						ph_n = PH_DISCARD;
				end else begin
					pc_n = 2'd0;
					pb_n = '0;
					if (len_bad) begin
						ph_n = PH_DISCARD;
					end else begin
						res.kind = RES_START;
						ul_n     = len[PKT_LEN_W-1:0];
						ph_n     = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				pl_n         = pl_dec;
				ul_n         = ul_dec;
				res.kind     = RES_BYTE;
				res.unit_end = (ul_dec == '0);
				if (ul_dec == '0)
					ph_n = (pl_dec == '0) ? PH_DISCARD : PH_PREFIX;
				else if (pl_dec == '0)
					ph_n = PH_DISCARD;
			end
			default: ph_n = PH_DISCARD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_DISCARD;
			prefix_count_q <= 2'd0;
			prefix_bytes_q <= '0;
			packet_left_q  <= '0;
			unit_left_q    <= '0;
			key_held_q     <= 1'b0;
			stamp_held_q   <= '0;
		end else if (consume) begin
			phase_q        <= ph_n;
			prefix_count_q <= pc_n;
			prefix_bytes_q <= pb_n;
			packet_left_q  <= pl_n;
			unit_left_q    <= ul_n;
			key_held_q     <= key;
			stamp_held_q   <= stamp;
		end
	end

endmodule

// ===== src/avcc_emit.sv =====
module avcc_emit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  avcc_pkg::res_desc_t                 res,
	input  logic                                load,
	output logic                                free,
	output logic                                tvalid,
	input  logic                                tready,
	output logic [avcc_pkg::M_TDATA_W-1:0]      tdata,
	output logic [avcc_pkg::M_TUSER_W-1:0]      tuser,
	output logic                                tlast
);
	import avcc_pkg::*;

	logic                      valid_q;
	logic                      last_q;
	logic [1:0]                beat_q;
	logic [1:0]                beat_nxt;
	logic [7:0]                byte_q;
	logic                      ustart_q;
	logic                      uend_q;
	logic                      key_q;
	logic signed [STAMP_W-1:0] stamp_q;
	logic                      step;
	logic                      is_start;

	assign free     = !valid_q || (tready && last_q);
	assign step     = valid_q && tready && !last_q;
	assign beat_nxt = beat_q + 2'd1;
	assign is_start = (res.kind == RES_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
			beat_q  <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			last_q  <= !is_start;
			beat_q  <= 2'd0;
		end else if (step) begin
			beat_q <= beat_nxt;
			last_q <= (beat_nxt == 2'd3);
		end else if (valid_q && tready) begin
			valid_q <= 1'b0;
		end
	end

	// start code walks through its four bytes, one per taken request
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= is_start ? start_code_byte(2'd0) : res.data;
			ustart_q <= is_start;
			uend_q   <= res.unit_end;
			key_q    <= res.key_frame;
			stamp_q  <= res.stamp;
		end else if (step) begin
			byte_q   <= start_code_byte(beat_nxt);
			ustart_q <= 1'b0;
		end
	end

	assign tvalid = valid_q;
	assign tdata  = {stamp_q, byte_q};
	assign tuser  = {key_q, uend_q, ustart_q};
	assign tlast  = last_q;

endmodule

// ===== src/avcc_to_annexb_converter_core.sv =====
// a byte is held in the input register and its result in the output register
// throughput: one byte per cycle unless the output stalls; the start code that
//   the fourth prefix byte yields holds the input until its four bytes go out
// the output register alone sets the rate; payload bytes stream without gaps
// reset: arst_n low clears the pipeline and drops all bytes until a packet start
module avcc_to_annexb_converter_core #(
	parameter int LENGTH_BITS = avcc_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// in_byte, packet_length, stamp_in
	input  logic [avcc_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// packet_first, key_frame_in
	input  logic [avcc_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_byte, stamp_out
	output logic [avcc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// unit_start, unit_end, key_frame_out
	output logic [avcc_pkg::M_TUSER_W-1:0] m_axis_tuser,
	// run_last
	output logic                           m_axis_tlast
);
	import avcc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	in_item_t  item_in;
	res_desc_t res;
	logic      free;
	logic      consume;
	logic      load;

	assign item_in.in_byte       = s_axis_tdata[7:0];
	assign item_in.packet_length = s_axis_tdata[8 +: PKT_LEN_W];
	assign item_in.stamp_in      = s_axis_tdata[8+PKT_LEN_W +: STAMP_W];
	assign item_in.packet_first  = s_axis_tuser[0];
	assign item_in.key_frame_in  = s_axis_tuser[1];

	// bytes with no result retire even while the output is busy
	assign consume       = valid_s1 && ((res.kind == RES_NONE) || free);
	assign load          = consume && (res.kind != RES_NONE);
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			item_s1 <= item_in;
	end

	avcc_parse #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.consume (consume),
		.res     (res)
	);

	avcc_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.res    (res),
		.load   (load),
		.free   (free),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata),
		.tuser  (m_axis_tuser),
		.tlast  (m_axis_tlast)
	);

endmodule

// ===== src/avcc_checker.sv =====
module avcc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [avcc_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [avcc_pkg::M_TUSER_W-1:0] m_axis_tuser,
	input logic                           m_axis_tlast
);

	// stalled output request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("output request changed while stalled");

	// input only backs up behind a pending output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with output empty");

	// first start code byte is zero and never closes the burst
	a_start_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata[7:0] == 8'h00) && !m_axis_tlast && !m_axis_tuser[1])
		else $error("bad unit start byte");

	// start code continues on the very next cycle
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[0] |=>
			m_axis_tvalid && !m_axis_tuser[0] && (m_axis_tdata[7:0] == 8'h00))
		else $error("start code burst broken");

	// unit end is a payload byte, always the only result of its input byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("unit end without run last");

endmodule

bind avcc_to_annexb_converter_core avcc_checker u_avcc_checker (.*);
